>>> rtl/wadm_pkg.sv
// package for the window absolute distance map unit
// constants, register codes, sequencer state and stage types; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wadm_pkg;

    // defaults for the storage parameters of the top level
    localparam int DEF_MAX_HEIGHT   = 256;
    localparam int DEF_MAX_WIDTH    = 256;
    localparam int DEF_MAX_CHANNELS = 4;

    // fixed field widths
    localparam int SAMPLE_W  = 16;
    localparam int DIST_W    = 18;
    localparam int TAP_W     = 6;
    localparam int CH_W      = 3;
    localparam int KER_W     = 4;
    localparam int DIL_W     = 5;
    localparam int SIZE_W    = 9;
    localparam int CRD_MIN_W = 11;
    localparam int IN_DATA_W = 56;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [KER_W-1:0]  KERN_MAX = 4'd8;
    localparam logic [DIST_W-1:0] DIST_MAX = 18'h3FFFF;

    // command codes carried in tuser
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_WINDOW = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMG_HEIGHT = 3'd0,
        REG_IMG_WIDTH  = 3'd1,
        REG_CHANNELS   = 3'd2,
        REG_KER_ROWS   = 3'd3,
        REG_KER_COLS   = 3'd4,
        REG_DIL_ROWS   = 3'd5,
        REG_DIL_COLS   = 3'd6
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CTR,
        ST_TAP,
        ST_DRAIN
    } t_state;

    // one store read in flight, with what to do with its data
    typedef struct packed {
        logic             kind_ctr;
        logic             zero;
        logic             first;
        logic             add;
        logic             emit;
        logic             last_tap;
        logic [CH_W-1:0]  ch;
        logic [TAP_W-1:0] tap;
    } t_s2;

endpackage

`default_nettype wire

>>> rtl/wadm_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module wadm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/window_abs_distance_map_unit.sv
// window absolute distance map: sample store, centre/tap read sequencer and distance unit
// depends on wadm_pkg and wadm_ram
//
// A write item (tuser 0) puts one sample into the store. A window item (tuser 1) reads
// the centre sample of each channel in use, then every tap of the window channel by channel
// through the one read port of the store, and a shared subtract, absolute-value and
// saturating-add unit builds each tap's distance. The reads go one at a time through the
// single store read port, and a stall on the output side holds them. The input is not ready
// while a window is in work; the last result may still wait in the output register when the
// next item is taken. The store is not cleared after reset: a window over samples never
// written gives undefined distances.
`timescale 1ns / 1ps
`default_nettype none

module window_abs_distance_map_unit
    import wadm_pkg::*;
#(
    parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // pix_row[7:0], pix_col[15:8], chan[17:16], sample[33:18], window_row[42:34],
    // window_col[51:43], zero fill[55:52]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // cmd[0]
    input  wire logic [0:0]            s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // distance[17:0], tap_index[23:18]
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                       m_axis_tlast,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int RB  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CB  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int KB  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int AW  = RB + CB + KB;
    localparam int DEPTH = 2 ** AW;
    localparam int RCB = (RB > CB) ? RB : CB;
    localparam int CW  = (RCB + 1 > CRD_MIN_W) ? RCB + 1 : CRD_MIN_W;

    // configuration
    logic [SIZE_W-1:0] r_img_height, r_img_width;
    logic [CH_W-1:0]   r_channels;
    logic [KER_W-1:0]  r_ker_rows, r_ker_cols;
    logic [DIL_W-1:0]  r_dil_rows, r_dil_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_height <= 9'd256;
            r_img_width  <= 9'd256;
            r_channels   <= 3'd1;
            r_ker_rows   <= 4'd3;
            r_ker_cols   <= 4'd3;
            r_dil_rows   <= 5'd1;
            r_dil_cols   <= 5'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_IMG_HEIGHT: r_img_height <= i_cfg_data;
                REG_IMG_WIDTH:  r_img_width  <= i_cfg_data;
                REG_CHANNELS:   r_channels   <= i_cfg_data[CH_W-1:0];
                REG_KER_ROWS:   r_ker_rows   <= i_cfg_data[KER_W-1:0];
                REG_KER_COLS:   r_ker_cols   <= i_cfg_data[KER_W-1:0];
                REG_DIL_ROWS:   r_dil_rows   <= i_cfg_data[DIL_W-1:0];
                REG_DIL_COLS:   r_dil_cols   <= i_cfg_data[DIL_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // saturated sizes
    logic [SIZE_W-1:0] h, w;
    logic [CH_W-1:0]   nch;
    logic [KER_W-1:0]  kr, kc;

    assign h   = (int'(r_img_height) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT) : r_img_height;
    assign w   = (int'(r_img_width) > MAX_WIDTH) ? SIZE_W'(MAX_WIDTH) : r_img_width;
    assign nch = (int'(r_channels) > MAX_CHANNELS) ? CH_W'(MAX_CHANNELS) : r_channels;
    assign kr  = (r_ker_rows > KERN_MAX) ? KERN_MAX : r_ker_rows;
    assign kc  = (r_ker_cols > KERN_MAX) ? KERN_MAX : r_ker_cols;

    function automatic logic f_inside(logic signed [CW-1:0] r, logic signed [CW-1:0] c,
                                      logic [SIZE_W-1:0] hh, logic [SIZE_W-1:0] ww);
        return !r[CW-1] && !c[CW-1] && (r < $signed(CW'(hh))) && (c < $signed(CW'(ww)));
    endfunction

    // input fields
    logic                       in_cmd;
    logic [7:0]                 in_pix_row, in_pix_col;
    logic [1:0]                 in_chan;
    logic signed [SAMPLE_W-1:0] in_sample;
    logic signed [8:0]          in_window_row, in_window_col;
    logic                       s_accept;

    assign in_cmd        = s_axis_tuser[0];
    assign in_pix_row    = s_axis_tdata[7:0];
    assign in_pix_col    = s_axis_tdata[15:8];
    assign in_chan       = s_axis_tdata[17:16];
    assign in_sample     = s_axis_tdata[33:18];
    assign in_window_row = s_axis_tdata[42:34];
    assign in_window_col = s_axis_tdata[51:43];
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // write path
    logic [CW-1:0]      wr_row, wr_col;
    logic [KB+CH_W-1:0] wr_ch;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;

    assign wr_row    = CW'(in_pix_row);
    assign wr_col    = CW'(in_pix_col);
    assign wr_ch     = (KB + CH_W)'(in_chan);
    assign ram_we    = s_accept && (in_cmd == CMD_WRITE) && (int'(in_pix_row) < MAX_HEIGHT)
                       && (int'(in_pix_col) < MAX_WIDTH) && (int'(in_chan) < MAX_CHANNELS);
    assign ram_waddr = {wr_row[RB-1:0], wr_col[CB-1:0], wr_ch[KB-1:0]};

    // window origin and centre
    logic signed [CW-1:0] w_r0, w_c0, w_cr, w_cc;
    logic [KER_W-1:0]     kr_m1, kc_m1;
    logic [6:0]           off_r, off_c;

    assign kr_m1 = kr - 4'd1;
    assign kc_m1 = kc - 4'd1;
    assign off_r = 7'(kr_m1[2:1]) * 7'(r_dil_rows);
    assign off_c = 7'(kc_m1[2:1]) * 7'(r_dil_cols);
    assign w_r0  = CW'(in_window_row);
    assign w_c0  = CW'(in_window_col);
    assign w_cr  = w_r0 + $signed(CW'(off_r));
    assign w_cc  = w_c0 + $signed(CW'(off_c));

    // sequencer state
    t_state               r_state, n_state;
    logic signed [CW-1:0] r_cr, r_cc, r_c0;
    logic                 r_cin;
    logic signed [CW-1:0] r_tr, n_tr, r_tc, n_tc;
    logic [CH_W-1:0]      r_ch, n_ch;
    logic [2:0]           r_i, n_i, r_j, n_j;
    logic [TAP_W-1:0]     r_tap, n_tap;

    // read stage
    logic                 r_s2_valid;
    t_s2                  r_s2, iss;
    logic                 issue, stall, emit_now;
    logic signed [CW-1:0] sel_row, sel_col;
    logic [KB+CH_W-1:0]   rd_ch;
    logic [AW-1:0]        ram_raddr;
    logic                 ram_re;
    logic [SAMPLE_W-1:0]  ram_rdata;
    logic                 tin, tap_last_row, tap_last_col;

    assign tin          = f_inside(r_tr, r_tc, h, w);
    assign tap_last_row = ({1'b0, r_i} == kr_m1);
    assign tap_last_col = ({1'b0, r_j} == kc_m1);
    assign stall        = r_s2_valid && !r_s2.kind_ctr && r_s2.emit
                          && m_axis_tvalid && !m_axis_tready;
    assign emit_now     = r_s2_valid && !r_s2.kind_ctr && r_s2.emit && !stall;

    always_comb begin
        n_state = r_state;
        n_ch    = r_ch;
        n_i     = r_i;
        n_j     = r_j;
        n_tap   = r_tap;
        n_tr    = r_tr;
        n_tc    = r_tc;
        issue   = 1'b0;
        iss     = '0;
        sel_row = r_tr;
        sel_col = r_tc;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept && in_cmd == CMD_WINDOW && kr != '0 && kc != '0) begin
                    n_ch    = '0;
                    n_i     = '0;
                    n_j     = '0;
                    n_tap   = '0;
                    n_tr    = w_r0;
                    n_tc    = w_c0;
                    n_state = (nch == '0) ? ST_TAP : ST_CTR;
                end
            end
            ST_CTR: begin
                sel_row = r_cr;
                sel_col = r_cc;
                if (!stall) begin
                    issue        = 1'b1;
                    iss.kind_ctr = 1'b1;
                    iss.zero     = !r_cin;
                    iss.ch       = r_ch;
                    if (r_ch == nch - 3'd1) begin
                        n_ch    = '0;
                        n_state = ST_TAP;
                    end else begin
                        n_ch = r_ch + 3'd1;
                    end
                end
            end
            ST_TAP: begin
                if (!stall) begin
                    issue        = 1'b1;
                    iss.zero     = !tin;
                    iss.first    = (r_ch == '0);
                    iss.add      = (nch != '0);
                    iss.emit     = (nch == '0) || (r_ch == nch - 3'd1);
                    iss.last_tap = tap_last_row && tap_last_col;
                    iss.ch       = r_ch;
                    iss.tap      = r_tap;
                    if (iss.emit) begin
                        n_ch  = '0;
                        n_tap = r_tap + 6'd1;
                        if (tap_last_col) begin
                            n_j  = '0;
                            n_tc = r_c0;
                            n_tr = r_tr + $signed(CW'(r_dil_rows));
                            n_i  = r_i + 3'd1;
                        end else begin
                            n_j  = r_j + 3'd1;
                            n_tc = r_tc + $signed(CW'(r_dil_cols));
                        end
                        if (iss.last_tap) begin
                            n_state = ST_DRAIN;
                        end
                    end else begin
                        n_ch = r_ch + 3'd1;
                    end
                end
            end
            ST_DRAIN: begin
                if (!r_s2_valid || !stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch  <= n_ch;
        r_i   <= n_i;
        r_j   <= n_j;
        r_tap <= n_tap;
        r_tr  <= n_tr;
        r_tc  <= n_tc;
        if (s_accept) begin
            r_c0  <= w_c0;
            r_cr  <= w_cr;
            r_cc  <= w_cc;
            r_cin <= f_inside(w_cr, w_cc, h, w);
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);

    assign rd_ch     = (KB + CH_W)'(iss.ch);
    assign ram_raddr = {sel_row[RB-1:0], sel_col[CB-1:0], rd_ch[KB-1:0]};
    assign ram_re    = issue && !iss.zero;

    wadm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (in_sample),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (!stall) begin
            r_s2_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s2 <= iss;
        end
    end

    // shared distance unit: centre minus tap, absolute value, saturating add
    logic signed [SAMPLE_W-1:0] r_ctr [2**KB];
    logic [KB+CH_W-1:0]         s2_ch;
    logic signed [SAMPLE_W-1:0] s2_v, ctr_v;
    logic signed [SAMPLE_W:0]   s2_d;
    logic [SAMPLE_W:0]          s2_ad;
    logic [DIST_W-1:0]          r_acc, acc_base, s2_sum;
    logic [DIST_W:0]            sum_wide;

    assign s2_ch    = (KB + CH_W)'(r_s2.ch);
    assign s2_v     = r_s2.zero ? '0 : $signed(ram_rdata);
    assign ctr_v    = r_ctr[s2_ch[KB-1:0]];
    assign s2_d     = (SAMPLE_W + 1)'(ctr_v) - (SAMPLE_W + 1)'(s2_v);
    assign s2_ad    = s2_d[SAMPLE_W] ? (SAMPLE_W + 1)'(-s2_d) : (SAMPLE_W + 1)'(s2_d);
    assign acc_base = r_s2.first ? '0 : r_acc;
    assign sum_wide = {1'b0, acc_base} + (r_s2.add ? (DIST_W + 1)'(s2_ad) : '0);
    assign s2_sum   = (sum_wide > (DIST_W + 1)'(DIST_MAX)) ? DIST_MAX : sum_wide[DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (r_s2_valid && !stall) begin
            if (r_s2.kind_ctr) begin
                r_ctr[s2_ch[KB-1:0]] <= s2_v;
            end else begin
                r_acc <= s2_sum;
            end
        end
    end

    // output register
    logic                    r_out_valid;
    logic [DIST_W-1:0]       r_out_dist;
    logic [TAP_W-1:0]        r_out_tap;
    logic                    r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_now) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_now) begin
            r_out_dist <= s2_sum;
            r_out_tap  <= r_s2.tap;
            r_out_last <= r_s2.last_tap;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_tap, r_out_dist};
    assign m_axis_tlast  = r_out_last;

    // the read stage is empty whenever a new item may be taken
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_s2_valid)
        else $error("read stage busy in idle");

    // channel counter stays within the channels in use
    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_TAP || r_state == ST_CTR) && nch != '0) |-> (r_ch < nch))
        else $error("channel counter out of range");

    // when the final tap leaves the unit no further tap reads are issued
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_now && r_s2.last_tap) |-> (r_state != ST_TAP && r_state != ST_CTR))
        else $error("tap reads after final tap");

    // a held result is never overwritten by the distance unit
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !emit_now)
        else $error("result overwritten while waiting");

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// testbench for window_abs_distance_map_unit: a directed table, then random windows over
// several register settings, all checked against an in-bench distance predictor
// depends on wadm_pkg and the rtl of the unit
module tb_top;
    import wadm_pkg::*;

    localparam int STORE_WORDS     = DEF_MAX_HEIGHT * DEF_MAX_WIDTH * DEF_MAX_CHANNELS;
    localparam int SETTLE_CYCLES   = 320;
    localparam int CYCLE_LIMIT     = 2000000;
    localparam int ITEMS_PER_PHASE = 20;
    localparam int RANDOM_PHASES   = 5;

    typedef struct {
        logic               cmd;
        logic [7:0]         pix_row;
        logic [7:0]         pix_col;
        logic [1:0]         chan;
        logic signed [15:0] samp_val;
        logic signed [8:0]  win_row;
        logic signed [8:0]  win_col;
        bit                 typed;
        int unsigned        typed_dist;
    } stim_item_t;

    typedef struct {
        logic [DIST_W-1:0] distance;
        logic [TAP_W-1:0]  tap_index;
        logic              last;
    } tap_result_t;

    typedef struct {
        int h;
        int w;
        int nch;
        int kr;
        int kc;
        int dr;
        int dc;
    } reg_set_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [0:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // predictor state: image copy, which entries the stimulus has filled, register copy
    logic signed [15:0] image_copy [0:STORE_WORDS-1];
    bit                 filled_map [0:STORE_WORDS-1];
    int                 cfg_height = 256;
    int                 cfg_width  = 256;
    int                 cfg_nch    = 1;
    int                 cfg_kr     = 3;
    int                 cfg_kc     = 3;
    int                 cfg_dr     = 1;
    int                 cfg_dc     = 1;

    tap_result_t pending_distances [$];
    int          err_count      = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          cycle_count    = 0;

    window_abs_distance_map_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int clip(int v, int hi);
        return (v > hi) ? hi : v;
    endfunction

    function automatic int store_addr(int r, int c, int ch);
        return (r * DEF_MAX_WIDTH + c) * DEF_MAX_CHANNELS + ch;
    endfunction

    function automatic bit in_image(int r, int c);
        return r >= 0 && c >= 0 && r < clip(cfg_height, DEF_MAX_HEIGHT)
            && c < clip(cfg_width, DEF_MAX_WIDTH);
    endfunction

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 3))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return $urandom;
        endcase
    endfunction

    function automatic stim_item_t make_write(int r, int c, int ch, logic signed [15:0] v);
        stim_item_t it;
        it.cmd        = CMD_WRITE;
        it.pix_row    = r[7:0];
        it.pix_col    = c[7:0];
        it.chan       = ch[1:0];
        it.samp_val   = v;
        it.win_row    = $urandom;
        it.win_col    = $urandom;
        it.typed      = 1'b0;
        it.typed_dist = 0;
        return it;
    endfunction

    function automatic stim_item_t make_window(int wr, int wc, bit typed, int unsigned d);
        stim_item_t it;
        it.cmd        = CMD_WINDOW;
        it.pix_row    = $urandom;
        it.pix_col    = $urandom;
        it.chan       = $urandom;
        it.samp_val   = $urandom;
        it.win_row    = wr[8:0];
        it.win_col    = wc[8:0];
        it.typed      = typed;
        it.typed_dist = d;
        return it;
    endfunction

    // one result per tap, row-major; centre and taps outside the image read as zero
    task automatic predict_window_distances(stim_item_t it);
        int          kr, kc, nch, r0, c0, cr, cc, tr, tc, n, cv, tv, diff;
        int unsigned sum;
        bit          cin, tin;
        tap_result_t res;
        kr  = clip(cfg_kr, KERN_MAX);
        kc  = clip(cfg_kc, KERN_MAX);
        nch = clip(cfg_nch, DEF_MAX_CHANNELS);
        r0  = int'(it.win_row);
        c0  = int'(it.win_col);
        cr  = r0 + ((kr > 0 ? kr - 1 : 0) / 2) * cfg_dr;
        cc  = c0 + ((kc > 0 ? kc - 1 : 0) / 2) * cfg_dc;
        cin = in_image(cr, cc);
        n   = 0;
        for (int i = 0; i < kr; i++) begin
            tr = r0 + i * cfg_dr;
            for (int j = 0; j < kc; j++) begin
                tc  = c0 + j * cfg_dc;
                tin = in_image(tr, tc);
                sum = 0;
                for (int ch = 0; ch < nch; ch++) begin
                    cv   = cin ? int'(image_copy[store_addr(cr, cc, ch)]) : 0;
                    tv   = tin ? int'(image_copy[store_addr(tr, tc, ch)]) : 0;
                    diff = cv - tv;
                    if (diff < 0) diff = -diff;
                    sum = sum + diff;
                    if (sum > DIST_MAX) sum = DIST_MAX;
                end
                res.distance  = it.typed ? it.typed_dist : sum;
                res.tap_index = n[TAP_W-1:0];
                res.last      = (i == kr - 1) && (j == kc - 1);
                pending_distances.push_back(res);
                n++;
            end
        end
    endtask

    task automatic send_item(stim_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.cmd;
        s_axis_tdata  <= {4'b0, it.win_col, it.win_row, it.samp_val, it.chan,
                          it.pix_col, it.pix_row};
        do @(posedge i_clk); while (!s_axis_tready);
        if (it.cmd == CMD_WRITE)
            image_copy[store_addr(it.pix_row, it.pix_col, it.chan)] = it.samp_val;
        else
            predict_window_distances(it);
    endtask

    // write every channel in use of a position that a window will read, if not yet written
    task automatic fill_position(int r, int c);
        int a;
        if (in_image(r, c)) begin
            for (int ch = 0; ch < clip(cfg_nch, DEF_MAX_CHANNELS); ch++) begin
                a = store_addr(r, c, ch);
                if (!filled_map[a]) begin
                    filled_map[a] = 1'b1;
                    send_item(make_write(r, c, ch, rand_sample()));
                end
            end
        end
    endtask

    task automatic send_window(stim_item_t it);
        int kr, kc, r0, c0;
        kr = clip(cfg_kr, KERN_MAX);
        kc = clip(cfg_kc, KERN_MAX);
        r0 = int'(it.win_row);
        c0 = int'(it.win_col);
        fill_position(r0 + ((kr > 0 ? kr - 1 : 0) / 2) * cfg_dr,
                      c0 + ((kc > 0 ? kc - 1 : 0) / 2) * cfg_dc);
        for (int i = 0; i < kr; i++)
            for (int j = 0; j < kc; j++)
                fill_position(r0 + i * cfg_dr, c0 + j * cfg_dc);
        send_item(it);
    endtask

    // origin chosen so that the window overlaps the image in use, or just misses it
    task automatic send_shaped_window();
        int lo_r, hi_r, lo_c, hi_c;
        lo_r = -((clip(cfg_kr, KERN_MAX) > 0 ? clip(cfg_kr, KERN_MAX) - 1 : 0) * cfg_dr);
        lo_c = -((clip(cfg_kc, KERN_MAX) > 0 ? clip(cfg_kc, KERN_MAX) - 1 : 0) * cfg_dc);
        if (lo_r < -256) lo_r = -256;
        if (lo_c < -256) lo_c = -256;
        hi_r = clip(clip(cfg_height, DEF_MAX_HEIGHT), 255);
        hi_c = clip(clip(cfg_width, DEF_MAX_WIDTH), 255);
        send_window(make_window(lo_r + $urandom_range(0, hi_r - lo_r),
                                lo_c + $urandom_range(0, hi_c - lo_c), 1'b0, 0));
    endtask

    task automatic write_reg(t_cfg_reg idx, int val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_IMG_HEIGHT: cfg_height = val & 'h1FF;
            REG_IMG_WIDTH:  cfg_width  = val & 'h1FF;
            REG_CHANNELS:   cfg_nch    = val & 'h7;
            REG_KER_ROWS:   cfg_kr     = val & 'hF;
            REG_KER_COLS:   cfg_kc     = val & 'hF;
            REG_DIL_ROWS:   cfg_dr     = val & 'h1F;
            REG_DIL_COLS:   cfg_dc     = val & 'h1F;
            default: ;
        endcase
    endtask

    task automatic load_regs(reg_set_t rs);
        write_reg(REG_IMG_HEIGHT, rs.h);
        write_reg(REG_IMG_WIDTH, rs.w);
        write_reg(REG_CHANNELS, rs.nch);
        write_reg(REG_KER_ROWS, rs.kr);
        write_reg(REG_KER_COLS, rs.kc);
        write_reg(REG_DIL_ROWS, rs.dr);
        write_reg(REG_DIL_COLS, rs.dc);
        i_cfg_valid <= 1'b0;
    endtask

    // hold the sender until every expected result is out, then, if asked to settle, let a
    // window with no results run to its end
    task automatic wait_drained(bit settle);
        s_axis_tvalid <= 1'b0;
        while (pending_distances.size() != 0) @(posedge i_clk);
        if (settle) repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : rx_check
        tap_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_distances.size() == 0) begin
                $error("result with no item waiting: distance %0d tap %0d",
                       m_axis_tdata[DIST_W-1:0], m_axis_tdata[DIST_W+TAP_W-1:DIST_W]);
                err_count++;
            end else begin
                want = pending_distances.pop_front();
                if (m_axis_tdata[DIST_W-1:0] !== want.distance) begin
                    $error("distance: expected %0d, got %0d", want.distance,
                           m_axis_tdata[DIST_W-1:0]);
                    err_count++;
                end
                if (m_axis_tdata[DIST_W+TAP_W-1:DIST_W] !== want.tap_index) begin
                    $error("tap_index: expected %0d, got %0d", want.tap_index,
                           m_axis_tdata[DIST_W+TAP_W-1:DIST_W]);
                    err_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
                    err_count++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial begin
        stim_item_t dir_tab [$];
        reg_set_t   phases [$];
        int         pick;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_IMG_HEIGHT;
        i_cfg_data    = '0;

        // reset settings: 256x256, one channel, 3x3 kernel, unit dilation
        dir_tab.push_back(make_window(-256, -256, 1'b1, 0));   // all of it off the image
        dir_tab.push_back(make_write(0, 0, 0, 16'sh7FFF));
        dir_tab.push_back(make_write(255, 255, 3, 16'sh8000));
        dir_tab.push_back(make_write(1, 1, 0, 16'sh8000));
        dir_tab.push_back(make_write(255, 0, 1, 16'sh5A5A));
        dir_tab.push_back(make_window(255, 255, 1'b0, 0));     // centre off, one tap on
        dir_tab.push_back(make_window(-1, -1, 1'b0, 0));       // centre on the corner
        dir_tab.push_back(make_window(0, 0, 1'b0, 0));
        dir_tab.push_back(make_window(-128, 255, 1'b1, 0));
        dir_tab.push_back(make_window(253, -2, 1'b0, 0));
        dir_tab.push_back(make_window(255, -256, 1'b1, 0));
        dir_tab.push_back(make_write(17, 200, 2, 16'sh0001));
        dir_tab.push_back(make_window(100, 100, 1'b0, 0));

        phases.push_back('{256, 256, 1, 3, 3, 1, 1});
        phases.push_back('{16, 16, 4, 8, 8, 2, 2});
        phases.push_back('{0, 511, 7, 15, 15, 31, 31});    // no row in use
        phases.push_back('{300, 1, 2, 1, 8, 0, 3});        // height saturates, no row step
        phases.push_back('{5, 7, 3, 0, 4, 1, 1});          // no kernel rows: no results
        phases.push_back('{1, 1, 4, 2, 2, 16, 16});
        phases.push_back('{8, 12, 0, 5, 3, 1, 2});         // no channels: all zero
        phases.push_back('{256, 256, 4, 8, 8, 31, 0});
        for (int p = 0; p < RANDOM_PHASES; p++)
            phases.push_back('{$urandom_range(1, 24), $urandom_range(1, 24),
                               $urandom_range(1, 4), $urandom_range(1, 8),
                               $urandom_range(1, 8), $urandom_range(0, 4),
                               $urandom_range(0, 4)});

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k]) begin
            if (dir_tab[k].cmd == CMD_WINDOW) send_window(dir_tab[k]);
            else send_item(dir_tab[k]);
        end

        foreach (phases[p]) begin
            wait_drained(1'b1);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            load_regs(phases[p]);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k == ITEMS_PER_PHASE / 2) wait_drained(1'b0);
                pick = $urandom_range(0, 99);
                if (pick < 25)
                    send_item(make_write($urandom_range(0, 255), $urandom_range(0, 255),
                                         $urandom_range(0, 3), rand_sample()));
                else if (pick < 30)
                    send_window(make_window($urandom_range(0, 511) - 256,
                                            $urandom_range(0, 511) - 256, 1'b0, 0));
                else
                    send_shaped_window();
            end
        end

        wait_drained(1'b1);
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/wadm_pkg.sv
rtl/wadm_ram.sv
rtl/window_abs_distance_map_unit.sv
dv/tb_top.sv
